>>> hdl/dine_pkg.sv
package dine_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration register fields
    localparam int FW_W     = 11;
    localparam int FH_W     = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(576);

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Arithmetic widths
    localparam int PIX_W   = 16;
    localparam int SQ_W    = 2 * PIX_W;        // square of a difference magnitude
    localparam int SUM_W   = SQ_W + 2;         // dx^2 + dy^2 + 4
    localparam int DIV_STEPS  = SQ_W;          // quotient bits of (m^2 << 32) / s
    localparam int SQRT_STEPS = DIV_STEPS / 2; // root bits
    localparam int ROOT_W  = SQRT_STEPS;
    localparam int SQR_REM_W = ROOT_W + 2;
    localparam int LANE_LAT  = DIV_STEPS + SQRT_STEPS + 2;

    // Control that travels alongside the arithmetic lanes
    typedef struct packed {
        logic valid;
        logic last;
        logic pos_x;
        logic pos_y;
        logic flat;
    } norm_ctl_t;

endpackage

>>> hdl/depth_image_normal_estimator.sv
// Depth image normal estimator. Takes one depth pixel per cycle in raster
// order and returns one unit normal (signed Q1.15, z saturating to 32767) per
// pixel, one row behind the input; after the last row, one row of flush items
// drains the final row. The block sustains one item per clock unless the
// output stalls; each item passes four stencil and arithmetic stages, the
// 1 + 32-stage divider and 1 + 16-stage square root of each normal component,
// and the output register. Both channels stall together: the whole pipeline
// holds while a result waits. Two 1024-entry line buffers alternate as current
// and previous row; they are not cleared at reset. Writing frame_width or
// frame_height restarts the frame and must happen while the block is idle.
module depth_image_normal_estimator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dine_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dine_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [15:0]                      s_depth_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_normal_x,
    output logic signed [15:0]               m_normal_y,
    output logic [14:0]                      m_normal_z,
    output logic                             m_last_of_frame
);
    import dine_pkg::*;

    // Pipeline advance
    logic adv;
    logic accept;
    logic m_valid_reg;
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign accept    = s_valid && adv;
    assign cfg_ready = 1'b1;

    // Configuration
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            cfg_hit;
    assign cfg_hit = cfg_valid &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_FRAME_WIDTH)
                frame_width_reg <= cfg_data[FW_W-1:0];
            if (cfg_index == REG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data[FH_W-1:0];
        end
    end

    // Effective frame size
    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;
    always_comb begin
        if (frame_width_reg == '0)
            w_eff = FW_W'(1);
        else if (frame_width_reg > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg == '0)
            h_eff = FH_W'(1);
        else if (frame_height_reg > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    // Frame sequencing
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             flushing_reg, flushing_next;
    logic             bank_reg, bank_next;   // 1: bank A holds the current row
    logic [COL_W-1:0] col_eff;
    logic [FW_W-1:0]  w_last;
    logic             row_end;
    logic             last_row;
    logic             is_pixel;
    logic             steps;
    logic             emits;
    logic             wr_en;

    always_comb begin
        w_last   = w_eff - FW_W'(1);
        col_eff  = ({1'b0, col_reg} >= w_eff) ? w_last[COL_W-1:0] : col_reg;
        row_end  = ({1'b0, col_eff} + FW_W'(1) >= w_eff);
        last_row = ({1'b0, row_reg} + FH_W'(1) >= h_eff);
        is_pixel = !flushing_reg && (s_kind == KIND_PIXEL);
        steps    = accept && (flushing_reg || is_pixel);
        emits    = flushing_reg || (is_pixel && row_reg != '0);
        wr_en    = accept && is_pixel;
    end

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        flushing_next = flushing_reg;
        bank_next     = bank_reg;
        if (cfg_hit) begin
            col_next      = '0;
            row_next      = '0;
            flushing_next = 1'b0;
        end else if (steps) begin
            if (!row_end) begin
                col_next = col_eff + COL_W'(1);
            end else if (flushing_reg) begin
                col_next      = '0;
                row_next      = '0;
                flushing_next = 1'b0;
            end else begin
                col_next  = '0;
                bank_next = !bank_reg;
                if (last_row)
                    flushing_next = 1'b1;
                else
                    row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            flushing_reg <= 1'b0;
            bank_reg     <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            flushing_reg <= flushing_next;
            bank_reg     <= bank_next;
        end
    end

    // Line buffers: each read at the column and the column to its right
    logic [PIX_W-1:0] mem_a [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] mem_b [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] a_c_reg, a_r_reg, b_c_reg, b_r_reg;
    logic [COL_W-1:0] addr_r;
    assign addr_r = col_eff + COL_W'(1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_c_reg <= mem_a[col_eff];
            a_r_reg <= mem_a[addr_r];
        end
        if (wr_en && bank_reg)
            mem_a[col_eff] <= s_depth_sample;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_c_reg <= mem_b[col_eff];
            b_r_reg <= mem_b[addr_r];
        end
        if (wr_en && !bank_reg)
            mem_b[col_eff] <= s_depth_sample;
    end

    // Stage 1: stencil flags and the pixel below
    logic             st1_valid_reg, st1_step_reg, st1_last_reg;
    logic             st1_first_reg, st1_right_reg, st1_above_reg, st1_below_reg;
    logic             st1_bank_reg;
    logic [PIX_W-1:0] st1_px_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st1_step_reg  <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= accept && emits;
            st1_step_reg  <= steps;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_last_reg  <= flushing_reg && row_end;
            st1_first_reg <= (col_eff == '0);
            st1_right_reg <= !row_end;
            st1_above_reg <= flushing_reg ? (h_eff >= FH_W'(2)) : (row_reg >= ROW_W'(2));
            st1_below_reg <= !flushing_reg;
            st1_bank_reg  <= bank_reg;
            st1_px_reg    <= s_depth_sample;
        end
    end

    // Stencil select and central differences
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] centre, left, right, above, below;
    logic signed [PIX_W:0] dx, dy;
    always_comb begin
        centre = st1_bank_reg ? b_c_reg : a_c_reg;
        left   = st1_first_reg ? centre : left_reg;
        right  = st1_right_reg ? (st1_bank_reg ? b_r_reg : a_r_reg) : centre;
        above  = st1_above_reg ? (st1_bank_reg ? a_c_reg : b_c_reg) : centre;
        below  = st1_below_reg ? st1_px_reg : centre;
        dx     = $signed({1'b0, right}) - $signed({1'b0, left});
        dy     = $signed({1'b0, below}) - $signed({1'b0, above});
    end

    // Centre of this column is the left neighbour of the next
    always_ff @(posedge aclk) begin
        if (adv && st1_step_reg)
            left_reg <= centre;
    end

    // Stage 2: magnitudes and signs
    logic             st2_valid_reg, st2_last_reg, st2_pos_x_reg, st2_pos_y_reg;
    logic [PIX_W-1:0] st2_mx_reg, st2_my_reg;
    logic [PIX_W:0]   abs_x, abs_y;
    always_comb begin
        abs_x = dx[PIX_W] ? $unsigned(-dx) : $unsigned(dx);
        abs_y = dy[PIX_W] ? $unsigned(-dy) : $unsigned(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            st2_valid_reg <= 1'b0;
        else if (adv)
            st2_valid_reg <= st1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_last_reg  <= st1_last_reg;
            st2_pos_x_reg <= !dx[PIX_W] && dx != '0;
            st2_pos_y_reg <= !dy[PIX_W] && dy != '0;
            st2_mx_reg    <= abs_x[PIX_W-1:0];
            st2_my_reg    <= abs_y[PIX_W-1:0];
        end
    end

    // Stage 3: squares
    norm_ctl_t       st3_ctl_reg;
    logic [SQ_W-1:0] st3_sx_reg, st3_sy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            st3_ctl_reg.valid <= 1'b0;
        else if (adv)
            st3_ctl_reg.valid <= st2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_ctl_reg.last  <= st2_last_reg;
            st3_ctl_reg.pos_x <= st2_pos_x_reg;
            st3_ctl_reg.pos_y <= st2_pos_y_reg;
            st3_ctl_reg.flat  <= 1'b0;
            st3_sx_reg        <= st2_mx_reg * st2_mx_reg;
            st3_sy_reg        <= st2_my_reg * st2_my_reg;
        end
    end

    // Stage 4: squared length of (dx, dy, 2)
    norm_ctl_t        st4_ctl_reg;
    logic [SQ_W-1:0]  st4_sx_reg, st4_sy_reg;
    logic [SUM_W-1:0] st4_s_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            st4_ctl_reg.valid <= 1'b0;
        else if (adv)
            st4_ctl_reg.valid <= st3_ctl_reg.valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st4_ctl_reg.last  <= st3_ctl_reg.last;
            st4_ctl_reg.pos_x <= st3_ctl_reg.pos_x;
            st4_ctl_reg.pos_y <= st3_ctl_reg.pos_y;
            st4_ctl_reg.flat  <= (st3_sx_reg == '0) && (st3_sy_reg == '0);
            st4_sx_reg        <= st3_sx_reg;
            st4_sy_reg        <= st3_sy_reg;
            st4_s_reg         <= {2'b00, st3_sx_reg} + {2'b00, st3_sy_reg} + SUM_W'(4);
        end
    end

    // Component lanes; a flat patch gives z = 1.0, set at the output
    logic [SQ_W-1:0]   dz;
    logic [ROOT_W-1:0] root_x, root_y, root_z;
    assign dz = st4_ctl_reg.flat ? '0 : SQ_W'(4);

    dine_root_lane u_lane_x (
        .aclk(aclk), .en(adv), .d_in(st4_sx_reg), .s_in(st4_s_reg), .root_out(root_x)
    );
    dine_root_lane u_lane_y (
        .aclk(aclk), .en(adv), .d_in(st4_sy_reg), .s_in(st4_s_reg), .root_out(root_y)
    );
    dine_root_lane u_lane_z (
        .aclk(aclk), .en(adv), .d_in(dz), .s_in(st4_s_reg), .root_out(root_z)
    );

    // Control delay matching the lanes
    norm_ctl_t ctl_pipe_reg [0:LANE_LAT-1];
    always_ff @(posedge aclk) begin
        if (!aresetn)
            ctl_pipe_reg[0] <= '0;
        else if (adv)
            ctl_pipe_reg[0] <= st4_ctl_reg;
    end

    for (genvar k = 1; k < LANE_LAT; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn)
                ctl_pipe_reg[k] <= '0;
            else if (adv)
                ctl_pipe_reg[k] <= ctl_pipe_reg[k-1];
        end
    end

    // Rounding, sign and saturation
    norm_ctl_t          ctl_end;
    logic [ROOT_W:0]    qx, qy, qz, nqx, nqy;
    logic [15:0]        x_next, y_next;
    logic [14:0]        z_next;
    always_comb begin
        ctl_end = ctl_pipe_reg[LANE_LAT-1];
        qx  = ({1'b0, root_x} + (ROOT_W+1)'(1)) >> 1;
        qy  = ({1'b0, root_y} + (ROOT_W+1)'(1)) >> 1;
        qz  = ({1'b0, root_z} + (ROOT_W+1)'(1)) >> 1;
        nqx = (ROOT_W+1)'(0) - qx;
        nqy = (ROOT_W+1)'(0) - qy;
        if (ctl_end.pos_x)
            x_next = nqx[15:0];
        else
            x_next = (qx > (ROOT_W+1)'(32767)) ? 16'h7FFF : qx[15:0];
        if (ctl_end.pos_y)
            y_next = nqy[15:0];
        else
            y_next = (qy > (ROOT_W+1)'(32767)) ? 16'h7FFF : qy[15:0];
        if (ctl_end.flat || qz > (ROOT_W+1)'(32767))
            z_next = 15'h7FFF;
        else
            z_next = qz[14:0];
    end

    // Output register
    logic [15:0] nx_reg, ny_reg;
    logic [14:0] nz_reg;
    logic        last_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= ctl_end.valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg   <= x_next;
            ny_reg   <= y_next;
            nz_reg   <= z_next;
            last_reg <= ctl_end.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_normal_x      = $signed(nx_reg);
    assign m_normal_y      = $signed(ny_reg);
    assign m_normal_z      = nz_reg;
    assign m_last_of_frame = last_reg;

endmodule

>>> hdl/dine_root_lane.sv
// One component: root = isqrt((d << 32) / s), d < s, as a restoring divider
// followed by a digit-by-digit square root, one bit per stage.
module dine_root_lane (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [dine_pkg::SQ_W-1:0]   d_in,
    input  logic [dine_pkg::SUM_W-1:0]  s_in,
    output logic [dine_pkg::ROOT_W-1:0] root_out
);
    import dine_pkg::*;

    logic [SUM_W-1:0]     div_rem_reg [0:DIV_STEPS];
    logic [SUM_W-1:0]     div_s_reg   [0:DIV_STEPS];
    logic [SQ_W-1:0]      div_q_reg   [0:DIV_STEPS];
    logic [SQR_REM_W-1:0] sq_rem_reg  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]    sq_root_reg [0:SQRT_STEPS];
    logic [SQ_W-1:0]      sq_val_reg  [0:SQRT_STEPS];

    // Divider entry: the high part of the dividend is d itself
    always_ff @(posedge aclk) begin
        if (en) begin
            div_rem_reg[0] <= {2'b00, d_in};
            div_s_reg[0]   <= s_in;
            div_q_reg[0]   <= '0;
        end
    end

    // Divider steps: shift in a zero, subtract when it fits
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [SUM_W:0] work;
        logic           ge;
        logic [SUM_W:0] diff;
        always_comb begin
            work = {div_rem_reg[k], 1'b0};
            diff = work - {1'b0, div_s_reg[k]};
            ge   = (work >= {1'b0, div_s_reg[k]});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[k+1] <= ge ? diff[SUM_W-1:0] : work[SUM_W-1:0];
                div_s_reg[k+1]   <= div_s_reg[k];
                div_q_reg[k+1]   <= {div_q_reg[k][SQ_W-2:0], ge};
            end
        end
    end

    // Square root entry
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_val_reg[0]  <= div_q_reg[DIV_STEPS];
        end
    end

    // Root steps: bring down two bits, try (root << 2) | 1
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [SQR_REM_W+1:0] work;
        logic [SQR_REM_W+1:0] trial;
        logic [SQR_REM_W+1:0] diff;
        logic                 ge;
        always_comb begin
            work  = {sq_rem_reg[k], sq_val_reg[k][SQ_W-1:SQ_W-2]};
            trial = {2'b00, sq_root_reg[k], 2'b01};
            diff  = work - trial;
            ge    = (work >= trial);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k+1]  <= ge ? diff[SQR_REM_W-1:0] : work[SQR_REM_W-1:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], ge};
                sq_val_reg[k+1]  <= {sq_val_reg[k][SQ_W-3:0], 2'b00};
            end
        end
    end

    assign root_out = sq_root_reg[SQRT_STEPS];

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dine_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 80;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [15:0]           s_depth_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [15:0]    m_normal_x;
    logic signed [15:0]    m_normal_y;
    logic [14:0]           m_normal_z;
    logic                  m_last_of_frame;

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [14:0] nz;
        logic        last;
    } normal_t;

    // Tracks the line buffers and frame position, predicts each normal
    class normal_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        logic [15:0] upper_row [MAX_WIDTH];
        logic [15:0] centre_row [MAX_WIDTH];
        int unsigned col;
        int unsigned row;
        bit          in_flush;
        normal_t     pending_normals [$];
        int          errors;

        function new();
            width_reg  = 640;
            height_reg = 576;
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                centre_row[i] = '0;
            end
            col      = 0;
            row      = 0;
            in_flush = 0;
            errors   = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // round(32768 * m / sqrt(s)), capped at 1.0
        function longint unsigned unit_mag(longint unsigned m, longint unsigned s);
            longint unsigned q;
            q = (int_sqrt(((m * m) << 32) / s) + 1) >> 1;
            return (q > 32768) ? 32768 : q;
        endfunction

        // component is -diff / norm
        function logic [15:0] diff_comp(int diff, longint unsigned s);
            longint unsigned m;
            longint unsigned q;
            m = (diff < 0) ? longint'(-diff) : longint'(diff);
            q = unit_mag(m, s);
            if (diff > 0) return 16'((65536 - q) & 16'hFFFF);
            return (q > 32767) ? 16'd32767 : 16'(q);
        endfunction

        function normal_t make_normal(int unsigned c, int unsigned w, logic [15:0] below,
                                      bit has_above, bit has_below, bit last);
            logic [15:0] ctr, lf, rt, up, dn;
            int dx, dy;
            longint unsigned s, z;
            normal_t n;
            ctr = centre_row[c];
            lf  = (c > 0) ? centre_row[c-1] : ctr;
            rt  = (c + 1 < w) ? centre_row[c+1] : ctr;
            up  = has_above ? upper_row[c] : ctr;
            dn  = has_below ? below : ctr;
            dx  = int'(rt) - int'(lf);
            dy  = int'(dn) - int'(up);
            s   = longint'(dx) * dx + longint'(dy) * dy + 4;
            z   = unit_mag(2, s);
            n.nx   = diff_comp(dx, s);
            n.ny   = diff_comp(dy, s);
            n.nz   = (z > 32767) ? 15'd32767 : 15'(z);
            n.last = last;
            return n;
        endfunction

        // Append one expected normal
        function void add_expected(normal_t n);
            pending_normals = {pending_normals, n};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_FRAME_WIDTH) width_reg = val & 16'h07FF;
            else if (idx == REG_FRAME_HEIGHT) height_reg = val & 16'h1FFF;
            else return;
            col      = 0;
            row      = 0;
            in_flush = 0;
        endfunction

        // Accepted input item
        function void note_item(logic kind, logic [15:0] depth);
            int unsigned w, h, c;
            bit row_end;
            logic [15:0] t;
            w = eff_w();
            h = eff_h();
            c = (col >= w) ? w - 1 : col;
            row_end = (c + 1 >= w);
            if (in_flush) begin
                add_expected(make_normal(c, w, 16'd0, h >= 2, 0, row_end));
                if (row_end) begin
                    col = 0;
                    row = 0;
                    in_flush = 0;
                end else begin
                    col = c + 1;
                end
                return;
            end
            // flush outside the flush row is dropped
            if (kind == KIND_FLUSH) return;
            if (row >= 1) add_expected(make_normal(c, w, depth, row >= 2, 1, 0));
            upper_row[c] = depth;
            if (row_end) begin
                for (int i = 0; i < MAX_WIDTH; i++) begin
                    t = upper_row[i];
                    upper_row[i]  = centre_row[i];
                    centre_row[i] = t;
                end
                col = 0;
                if (row + 1 >= h) in_flush = 1;
                else row = row + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        function void check_normal(logic [15:0] nx, logic [15:0] ny, logic [14:0] nz,
                                   logic last);
            normal_t e;
            if (pending_normals.size() == 0) begin
                $error("unexpected normal x=%0d y=%0d z=%0d", $signed(nx), $signed(ny), nz);
                errors++;
                return;
            end
            e = pending_normals.pop_front();
            if (nx !== e.nx) begin
                $error("normal_x expected %0d actual %0d", $signed(e.nx), $signed(nx));
                errors++;
            end
            if (ny !== e.ny) begin
                $error("normal_y expected %0d actual %0d", $signed(e.ny), $signed(ny));
                errors++;
            end
            if (nz !== e.nz) begin
                $error("normal_z expected %0d actual %0d", e.nz, nz);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_frame expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    normal_scoreboard sb;
    bit quiet;
    int items_sent;
    logic [15:0] last_depth;

    depth_image_normal_estimator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_depth_sample  (s_depth_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_normal_x      (m_normal_x),
        .m_normal_y      (m_normal_y),
        .m_normal_z      (m_normal_z),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Result side: random back-pressure, checking, watchdog
    initial begin
        int stall;
        int idle_cycles;
        stall = 0;
        idle_cycles = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_normal(m_normal_x, m_normal_y, m_normal_z, m_last_of_frame);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= (stall == 0);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(logic kind, logic [15:0] depth);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_depth_sample <= depth;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(kind, depth);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_normals.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One write; valid drops for a cycle before the next write can start
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Set geometry, random bits above the field width
    task automatic set_geometry(int unsigned w, int unsigned h);
        write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(w)});
        write_reg(REG_FRAME_HEIGHT, {3'($urandom), 13'(h)});
    endtask

    // Mostly smooth surfaces, with extremes and full-range noise
    function automatic logic [15:0] pick_depth();
        case ($urandom_range(0, 5))
            0: pick_depth = 16'h0000;
            1: pick_depth = 16'hFFFF;
            2: pick_depth = 16'($urandom);
            default: pick_depth = last_depth + 16'($urandom_range(0, 64)) - 16'd32;
        endcase
        last_depth = pick_depth;
    endfunction

    // One frame of pixel rows and its flush row; rows_cut > 0 stops early
    task automatic send_frame(int unsigned rows_cut, int noise_pct);
        int unsigned w, h, rows;
        w = sb.eff_w();
        h = sb.eff_h();
        rows = (rows_cut > 0 && rows_cut < h) ? rows_cut : h;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(0, 99) < noise_pct) push_item(KIND_FLUSH, 16'($urandom));
                push_item(KIND_PIXEL, pick_depth());
            end
        if (rows < h) return;
        for (int c = 0; c < w; c++) begin
            if ($urandom_range(0, 99) < noise_pct) push_item(KIND_PIXEL, 16'($urandom));
            else push_item(KIND_FLUSH, 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        quiet = 0;
        items_sent = 0;
        last_depth = 16'd1000;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_kind = KIND_PIXEL;
        s_depth_sample = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 3x3 with extremes, stray flush in pixel rows, pixel in flush row
        set_geometry(3, 3);
        push_item(KIND_PIXEL, 16'h0000);
        push_item(KIND_PIXEL, 16'hFFFF);
        push_item(KIND_FLUSH, 16'h1234);
        push_item(KIND_PIXEL, 16'h0000);
        push_item(KIND_PIXEL, 16'hFFFF);
        push_item(KIND_PIXEL, 16'h0000);
        push_item(KIND_PIXEL, 16'hFFFF);
        push_item(KIND_PIXEL, 16'h0000);
        push_item(KIND_PIXEL, 16'hFFFF);
        push_item(KIND_PIXEL, 16'h0000);
        push_item(KIND_FLUSH, 16'h0000);
        push_item(KIND_PIXEL, 16'hFFFF);
        push_item(KIND_FLUSH, 16'hFFFF);
        drain();
        // Zero width and height act as one; a write to an unused index
        set_geometry(0, 0);
        write_reg(CFG_IDX_W'(15), 16'hFFFF);
        push_item(KIND_PIXEL, 16'hFFFF);
        push_item(KIND_FLUSH, 16'h0000);
        drain();
        // A wider row
        set_geometry(64, 2);
        send_frame(0, 0);
        drain();
        // Height above the maximum: a few rows, then restart
        set_geometry(2, 8191);
        send_frame(6, 5);
        drain();
        set_geometry(4, 3);

        // Random frames
        while (items_sent < 880) begin
            if (items_sent > 780) quiet = 1;
            if ($urandom_range(0, 2) != 0) begin
                drain();
                if ($urandom_range(0, 9) == 0)
                    set_geometry($urandom_range(16, 40), $urandom_range(1, 3));
                else
                    set_geometry($urandom_range(1, 8), $urandom_range(1, 6));
            end
            if ($urandom_range(0, 7) == 0) begin
                send_frame($urandom_range(1, 3), 10);
                drain();
                set_geometry(sb.eff_w(), sb.eff_h());
            end else begin
                send_frame(0, $urandom_range(0, 1) ? 0 : 8);
            end
        end
        drain();

        if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> depth_image_normal_estimator.f
hdl/dine_pkg.sv
hdl/dine_root_lane.sv
hdl/depth_image_normal_estimator.sv
tb/tb_top.sv
